// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/cesu8_pkg.sv =====
// Shared types and constants for the CESU-8 chunk decoder.
// No dependencies; used by cesu8_chunk_decoder.
`default_nettype none

package cesu8_pkg;

  // Decoder phase
  typedef enum logic [2:0] {
    PH_LEN_HI    = 3'd0,
    PH_LEN_LO    = 3'd1,
    PH_LEAD      = 3'd2,
    PH_TWO       = 3'd3,
    PH_THREE_OK  = 3'd4,
    PH_THREE_BAD = 3'd5,
    PH_LOW_OK    = 3'd6,
    PH_LOW_BAD   = 3'd7
  } phase_e;

  // One result transfer
  typedef struct packed {
    logic [20:0] code_point;
    logic        char_valid;
    logic        chunk_last;
    logic        decode_error;
  } result_t;

  localparam logic [25:0] SURR_OFFSET  = 26'h35F_DC00;
  localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
  localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;
  localparam logic [15:0] NONCHAR_LO   = 16'hFFFE;
  localparam logic [15:0] MIN_THREE    = 16'h0800;
  localparam logic [15:0] MIN_TWO      = 16'h0080;

  // Continuation byte: 10xxxxxx
  function automatic logic is_cont(input logic [7:0] b);
    is_cont = (b[7:6] == 2'b10);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cesu8_chunk_decoder.sv =====
// CESU-8 chunk decoder top level: header parse, character decode, output stage.
// Depends on cesu8_pkg.
`default_nettype none

// The decoder takes one byte per cycle while in_stall_o is low.
// A chunk starts with a two-byte big-endian character count, followed by that
// many CESU-8 characters; each finished character gives one result, with
// chunk_last set on the last one, and a zero count gives a single empty
// end-of-chunk result. A result is registered into the output register or,
// while the output is stalled, into the skid entry. The output side is a
// result register backed by one skid entry, so a byte is still taken while a
// result waits; in_stall_o rises only once both are full, i.e. after the
// output has been stalled for two results in a row. Any decode error gives
// one result with decode_error set; the decoder then waits for a new header.
module cesu8_chunk_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [20:0]      code_point_o,
  output logic             char_valid_o,
  output logic             chunk_last_o,
  output logic             decode_error_o
);

  cesu8_pkg::phase_e phase_q, phase_d;
  logic [7:0]        len_hi_q, len_hi_d;
  logic [15:0]       chars_left_q, chars_left_d;
  logic [15:0]       partial_q, partial_d;
  logic [1:0]        bytes_seen_q, bytes_seen_d;
  logic [15:0]       high_surr_q, high_surr_d;

  logic              out_valid_q, skid_valid_q;
  cesu8_pkg::result_t out_q, skid_q;

  logic              take;
  logic              res_vld;
  cesu8_pkg::result_t res;
  logic              do_char, do_err;
  logic [20:0]       char_cp;
  logic [15:0]       chars_dec;
  logic [15:0]       count;
  logic [15:0]       val;
  logic [25:0]       pair_sum;
  logic              out_free;

  assign take     = in_valid_i && !in_stall_o;
  assign chars_dec = chars_left_q - 16'd1;
  assign count    = {len_hi_q, in_byte_i};
  assign val      = partial_q | {10'd0, in_byte_i[5:0]};
  assign pair_sum = {high_surr_q, 10'd0} - cesu8_pkg::SURR_OFFSET + {10'd0, val};

  // Next state and result for the byte on the input
  always_comb begin
    phase_d      = phase_q;
    len_hi_d     = len_hi_q;
    chars_left_d = chars_left_q;
    partial_d    = partial_q;
    bytes_seen_d = bytes_seen_q;
    high_surr_d  = high_surr_q;
    res_vld      = 1'b0;
    res          = '0;
    do_char      = 1'b0;
    do_err       = 1'b0;
    char_cp      = '0;

    unique case (phase_q)
      cesu8_pkg::PH_LEN_HI: begin
        len_hi_d = in_byte_i;
        phase_d  = cesu8_pkg::PH_LEN_LO;
      end
      cesu8_pkg::PH_LEN_LO: begin
        if (count == 16'd0) begin
          // empty chunk marker
          phase_d        = cesu8_pkg::PH_LEN_HI;
          len_hi_d       = '0;
          chars_left_d   = '0;
          partial_d      = '0;
          bytes_seen_d   = '0;
          high_surr_d    = '0;
          res_vld        = 1'b1;
          res.chunk_last = 1'b1;
        end else begin
          chars_left_d = count;
          phase_d      = cesu8_pkg::PH_LEAD;
        end
      end
      cesu8_pkg::PH_LEAD: begin
        if (!in_byte_i[7]) begin
          do_char = 1'b1;
          char_cp = {13'd0, in_byte_i};
        end else if (in_byte_i[7:5] == 3'b110) begin
          partial_d = {5'd0, in_byte_i[4:0], 6'd0};
          phase_d   = cesu8_pkg::PH_TWO;
        end else if (in_byte_i[7:4] == 4'b1110) begin
          partial_d    = {in_byte_i[3:0], 12'd0};
          bytes_seen_d = 2'd0;
          phase_d      = cesu8_pkg::PH_THREE_OK;
        end else begin
          do_err = 1'b1;
        end
      end
      cesu8_pkg::PH_TWO: begin
        if (val >= cesu8_pkg::MIN_TWO && cesu8_pkg::is_cont(in_byte_i)) begin
          do_char = 1'b1;
          char_cp = {5'd0, val};
        end else begin
          do_err = 1'b1;
        end
      end
      cesu8_pkg::PH_THREE_OK, cesu8_pkg::PH_THREE_BAD: begin
        if (bytes_seen_q == 2'd0) begin
          partial_d    = partial_q | {4'd0, in_byte_i[5:0], 6'd0};
          bytes_seen_d = 2'd1;
          if (!cesu8_pkg::is_cont(in_byte_i)) phase_d = cesu8_pkg::PH_THREE_BAD;
        end else if (phase_q == cesu8_pkg::PH_THREE_BAD || !cesu8_pkg::is_cont(in_byte_i)
                     || val < cesu8_pkg::MIN_THREE || val >= cesu8_pkg::NONCHAR_LO
                     || (val >= cesu8_pkg::LOW_SURR_LO && val <= cesu8_pkg::LOW_SURR_HI)) begin
          // lone low surrogate lands here too
          do_err = 1'b1;
        end else if (val >= cesu8_pkg::HIGH_SURR_LO && val < cesu8_pkg::LOW_SURR_LO) begin
          // high surrogate: wait for its low half
          high_surr_d  = val;
          partial_d    = '0;
          bytes_seen_d = 2'd0;
          phase_d      = cesu8_pkg::PH_LOW_OK;
        end else begin
          do_char = 1'b1;
          char_cp = {5'd0, val};
        end
      end
      cesu8_pkg::PH_LOW_OK, cesu8_pkg::PH_LOW_BAD: begin
        case (bytes_seen_q)
          2'd0: begin
            if (in_byte_i[7:4] != 4'b1110) phase_d = cesu8_pkg::PH_LOW_BAD;
            partial_d    = {in_byte_i[3:0], 12'd0};
            bytes_seen_d = 2'd1;
          end
          2'd1: begin
            if (!cesu8_pkg::is_cont(in_byte_i)) phase_d = cesu8_pkg::PH_LOW_BAD;
            partial_d    = partial_q | {4'd0, in_byte_i[5:0], 6'd0};
            bytes_seen_d = 2'd2;
          end
          default: begin
            if (phase_q != cesu8_pkg::PH_LOW_OK || !cesu8_pkg::is_cont(in_byte_i)
                || val < cesu8_pkg::LOW_SURR_LO || val > cesu8_pkg::LOW_SURR_HI) begin
              do_err = 1'b1;
            end else begin
              do_char = 1'b1;
              char_cp = pair_sum[20:0];
            end
          end
        endcase
      end
      default: begin
        do_err = 1'b1;
      end
    endcase

    // finished character
    if (do_char) begin
      chars_left_d   = chars_dec;
      partial_d      = '0;
      bytes_seen_d   = '0;
      high_surr_d    = '0;
      phase_d        = (chars_dec == 16'd0) ? cesu8_pkg::PH_LEN_HI : cesu8_pkg::PH_LEAD;
      res_vld        = 1'b1;
      res.code_point = char_cp;
      res.char_valid = 1'b1;
      res.chunk_last = (chars_dec == 16'd0);
    end

    // error: drop the rest of the chunk
    if (do_err) begin
      phase_d          = cesu8_pkg::PH_LEN_HI;
      len_hi_d         = '0;
      chars_left_d     = '0;
      partial_d        = '0;
      bytes_seen_d     = '0;
      high_surr_d      = '0;
      res_vld          = 1'b1;
      res              = '0;
      res.decode_error = 1'b1;
    end
  end

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= cesu8_pkg::PH_LEN_HI;
      len_hi_q     <= '0;
      chars_left_q <= '0;
      partial_q    <= '0;
      bytes_seen_q <= '0;
      high_surr_q  <= '0;
    end else if (take) begin
      phase_q      <= phase_d;
      len_hi_q     <= len_hi_d;
      chars_left_q <= chars_left_d;
      partial_q    <= partial_d;
      bytes_seen_q <= bytes_seen_d;
      high_surr_q  <= high_surr_d;
    end
  end

  // Output register plus skid entry
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || (take && res_vld);
      skid_valid_q <= 1'b0;
    end else if (take && res_vld) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (take && res_vld) begin
      skid_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign code_point_o   = out_q.code_point;
  assign char_valid_o   = out_q.char_valid;
  assign chunk_last_o   = out_q.chunk_last;
  assign decode_error_o = out_q.decode_error;

endmodule

`default_nettype wire

// ===== rtl/cesu8_chk.sv =====
// Port-level checker for the CESU-8 chunk decoder, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cesu8_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [20:0] code_point_o,
  input wire logic        char_valid_o,
  input wire logic        chunk_last_o,
  input wire logic        decode_error_o
);

  // a stalled result stays presented
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // input backpressure only follows a stalled output
  `ASSERT_IMPLY(a_stall_cause, clk_i, rst_ni, in_stall_o, $past(out_valid_o && out_stall_i))

  // error results carry nothing else
  `ASSERT_IMPLY(a_err_clean, clk_i, rst_ni, out_valid_o && decode_error_o, !char_valid_o && !chunk_last_o && code_point_o == 21'd0)

  // non-character results have a zero code point
  `ASSERT_IMPLY(a_cp_zero, clk_i, rst_ni, out_valid_o && !char_valid_o, code_point_o == 21'd0)

endmodule

bind cesu8_chunk_decoder cesu8_chk u_cesu8_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .code_point_o   (code_point_o),
  .char_valid_o   (char_valid_o),
  .chunk_last_o   (chunk_last_o),
  .decode_error_o (decode_error_o)
);

`default_nettype wire
